// ===== design/stpseq_pkg.sv =====
`timescale 1ns / 1ps

package stpseq_pkg;

    localparam int STEP_COUNT_BITS_DEF = 16;

    localparam int WAIT_W     = 11;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;
    localparam int SPEED_W    = 7;
    localparam int CNT_IN_W   = 16;

    localparam logic [WAIT_W-1:0]  WAIT_BASE = 11'd1050;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    localparam logic [PHASE_W-1:0] PHASE_NONE  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd4;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]          action;
        logic                direction;
        logic [SPEED_W-1:0]  speed;
        logic [CNT_IN_W-1:0] step_count;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              stepped;
        logic              finished;
        logic              busy_res;
    } t_out_item;

    // Motion state without the step counter, whose width is a parameter
    typedef struct packed {
        logic               moving;
        logic [PHASE_W-1:0] last_phase;
        logic               reverse;
        logic [COIL_W-1:0]  coil_pattern;
        logic [WAIT_W-1:0]  wait_left;
        logic [WAIT_W-1:0]  wait_reload;
    } t_state;

    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                      input logic rev);
        logic [PHASE_W-1:0] n;
        if (rev) begin
            n = (p <= PHASE_FIRST || p > PHASE_LAST) ? PHASE_LAST : p - 3'd1;
        end else begin
            n = (p >= PHASE_LAST) ? PHASE_FIRST : p + 3'd1;
        end
        return n;
    endfunction

    function automatic logic [COIL_W-1:0] phase_coils(input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] c;
        unique case (p[1:0])
            2'd1:    c = 4'b0011;
            2'd2:    c = 4'b0110;
            2'd3:    c = 4'b1100;
            default: c = 4'b1001;
        endcase
        return c;
    endfunction

endpackage

// ===== design/stpseq_step_logic.sv =====
`timescale 1ns / 1ps

module stpseq_step_logic #(
    parameter int STEP_COUNT_BITS = stpseq_pkg::STEP_COUNT_BITS_DEF
) (
    input  stpseq_pkg::t_in_item         i_item,
    input  stpseq_pkg::t_state           i_state,
    input  logic [STEP_COUNT_BITS-1:0]   i_steps_left,
    output stpseq_pkg::t_state           o_state,
    output logic [STEP_COUNT_BITS-1:0]   o_steps_left,
    output stpseq_pkg::t_out_item        o_result
);

    logic [stpseq_pkg::SPEED_W-1:0]  spd;
    logic [stpseq_pkg::WAIT_W-1:0]   reload;
    logic [31:0]                     cnt_ext;
    logic [STEP_COUNT_BITS-1:0]      cnt;
    logic [stpseq_pkg::WAIT_W-1:0]   wl_dec;
    logic [stpseq_pkg::PHASE_W-1:0]  start_phase;
    logic [stpseq_pkg::PHASE_W-1:0]  tick_phase;
    logic                            stepped;
    logic                            finished;

    assign spd = (i_item.speed > stpseq_pkg::SPEED_MAX) ? stpseq_pkg::SPEED_MAX
                                                        : i_item.speed;
    // 10 * speed as 8x + 2x
    assign reload = stpseq_pkg::WAIT_BASE
                    - (11'({spd, 3'b000}) + 11'({spd, 1'b0}));
    assign cnt_ext = {16'd0, i_item.step_count};
    assign cnt     = cnt_ext[STEP_COUNT_BITS-1:0];
    assign wl_dec  = (i_state.wait_left != '0) ? i_state.wait_left - 11'd1
                                               : i_state.wait_left;
    assign start_phase = stpseq_pkg::next_phase(i_state.last_phase, i_item.direction);
    assign tick_phase  = stpseq_pkg::next_phase(i_state.last_phase, i_state.reverse);

    always_comb begin
        o_state      = i_state;
        o_steps_left = i_steps_left;
        stepped      = 1'b0;
        finished     = 1'b0;
        unique case (stpseq_pkg::t_action'(i_item.action))
            stpseq_pkg::ACT_START: begin
                o_state.reverse     = i_item.direction;
                o_state.wait_reload = reload;
                if (cnt == '0) begin
                    o_state.moving    = 1'b0;
                    o_state.wait_left = '0;
                    o_steps_left      = '0;
                    finished          = 1'b1;
                end else begin
                    o_state.last_phase   = start_phase;
                    o_state.coil_pattern = stpseq_pkg::phase_coils(start_phase);
                    o_state.wait_left    = reload;
                    o_state.moving       = 1'b1;
                    o_steps_left         = cnt - STEP_COUNT_BITS'(1);
                    stepped              = 1'b1;
                end
            end
            stpseq_pkg::ACT_STOP: begin
                o_state.moving    = 1'b0;
                o_state.wait_left = '0;
                o_steps_left      = '0;
            end
            stpseq_pkg::ACT_TICK: begin
                if (i_state.moving) begin
                    o_state.wait_left = wl_dec;
                    if (wl_dec == '0) begin
                        if (i_steps_left != '0) begin
                            o_state.last_phase   = tick_phase;
                            o_state.coil_pattern = stpseq_pkg::phase_coils(tick_phase);
                            o_state.wait_left    = i_state.wait_reload;
                            o_steps_left         = i_steps_left - STEP_COUNT_BITS'(1);
                            stepped              = 1'b1;
                        end else begin
                            o_state.moving = 1'b0;
                            finished       = 1'b1;
                        end
                    end
                end
            end
            stpseq_pkg::ACT_NONE: begin
                // ignored code: state holds
            end
        endcase
        o_result.coils    = o_state.coil_pattern;
        o_result.stepped  = stepped;
        o_result.finished = finished;
        o_result.busy_res = o_state.moving;
    end

endmodule

// ===== design/stepper_full_step_sequencer_core.sv =====
`timescale 1ns / 1ps

// Full-step sequencer for one four-coil stepper (patterns 0011, 0110, 1100,
// 1001). Each input item is a millisecond tick, a start, a stop or an ignored
// code, and each gives exactly one result item with the coil pattern, a step
// pulse, a finished pulse and the busy flag. An item passes through an input
// register and a result register: it waits in the input register until the
// result register is free, and the result is held there until taken. One
// item is accepted every cycle while the result side keeps taking. A start
// takes its first step at once; later steps follow after 1050 - 10 * speed
// ticks, with speed capped at 100. The phase reached is kept across moves.
module stepper_full_step_sequencer_core #(
    parameter int STEP_COUNT_BITS = stpseq_pkg::STEP_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  stpseq_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output stpseq_pkg::t_out_item o_out_item
);

    logic                       r_in_valid;
    stpseq_pkg::t_in_item       r_in_item;
    stpseq_pkg::t_state         r_state;
    stpseq_pkg::t_state         n_state;
    logic [STEP_COUNT_BITS-1:0] r_steps_left;
    logic [STEP_COUNT_BITS-1:0] n_steps_left;
    logic                       r_out_valid;
    stpseq_pkg::t_out_item      r_out_item;
    stpseq_pkg::t_out_item      n_out_item;
    logic                       w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    stpseq_step_logic #(
        .STEP_COUNT_BITS(STEP_COUNT_BITS)
    ) u_step_logic (
        .i_item       (r_in_item),
        .i_state      (r_state),
        .i_steps_left (r_steps_left),
        .o_state      (n_state),
        .o_steps_left (n_steps_left),
        .o_result     (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_steps_left <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_state      <= n_state;
                r_steps_left <= n_steps_left;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== design/stpseq_checker.sv =====
`timescale 1ns / 1ps

module stpseq_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input stpseq_pkg::t_out_item o_out_item
);

    // hold a stalled result item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.stepped && o_out_item.finished))
        else $error("step and finish in one item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.finished |-> !o_out_item.busy_res)
        else $error("finished while still busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.stepped |-> o_out_item.busy_res)
        else $error("step taken without a running move");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.stepped |->
            (o_out_item.coils == 4'b0011 || o_out_item.coils == 4'b0110 ||
             o_out_item.coils == 4'b1100 || o_out_item.coils == 4'b1001))
        else $error("step drove an invalid coil pattern");

endmodule

bind stepper_full_step_sequencer_core stpseq_checker u_stpseq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 8;
    localparam int PIPE_DRAIN  = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int CMD_TARGET  = 600;
    localparam logic [stpseq_pkg::WAIT_W-1:0] WAIT_STEP = 11'd10;

    typedef struct packed {
        logic                           moving;
        logic [stpseq_pkg::PHASE_W-1:0] phase;
        logic [15:0]                    steps_left;
        logic [stpseq_pkg::WAIT_W-1:0]  wait_left;
        logic [stpseq_pkg::WAIT_W-1:0]  wait_reload;
        logic                           reverse;
        logic [stpseq_pkg::COIL_W-1:0]  coils;
    } t_motor_state;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    stpseq_pkg::t_in_item  i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    stpseq_pkg::t_out_item o_out_item;

    stepper_full_step_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    stpseq_pkg::t_in_item  pending_commands[$];
    stpseq_pkg::t_out_item results_due[$];
    t_motor_state          plan_state;
    t_motor_state          dut_model;
    int                    planned_effective;
    int                    total_cmds;
    int                    cmds_accepted;
    int                    errors;
    int                    steps_seen;
    int                    moves_finished;
    int                    stall_cycles;
    logic                  in_took;

    always #CLK_HALF i_clk = ~i_clk;

    // Advance one phase in the stored direction; no phase yet counts as phase 0.
    function automatic t_motor_state take_step(input t_motor_state cur);
        t_motor_state s;
        s = cur;
        if (s.reverse) begin
            s.phase = (s.phase <= stpseq_pkg::PHASE_FIRST || s.phase > stpseq_pkg::PHASE_LAST)
                      ? stpseq_pkg::PHASE_LAST : s.phase - 3'd1;
        end else begin
            s.phase = (s.phase >= stpseq_pkg::PHASE_LAST) ? stpseq_pkg::PHASE_FIRST
                                                          : s.phase + 3'd1;
        end
        case (s.phase)
            3'd1:    s.coils = 4'b0011;
            3'd2:    s.coils = 4'b0110;
            3'd3:    s.coils = 4'b1100;
            default: s.coils = 4'b1001;
        endcase
        return s;
    endfunction

    function automatic stpseq_pkg::t_out_item advance_motor(
        input  t_motor_state         cur,
        input  stpseq_pkg::t_in_item cmd,
        output t_motor_state         nxt
    );
        t_motor_state                   s;
        stpseq_pkg::t_out_item          r;
        logic [stpseq_pkg::SPEED_W-1:0] spd;
        s = cur;
        r.stepped  = 1'b0;
        r.finished = 1'b0;
        case (cmd.action)
            stpseq_pkg::ACT_START: begin
                spd           = (cmd.speed > stpseq_pkg::SPEED_MAX) ? stpseq_pkg::SPEED_MAX
                                                                    : cmd.speed;
                s.reverse     = cmd.direction;
                s.wait_reload = stpseq_pkg::WAIT_BASE
                                - stpseq_pkg::WAIT_W'(spd) * WAIT_STEP;
                if (cmd.step_count == '0) begin
                    s.moving     = 1'b0;
                    s.steps_left = '0;
                    s.wait_left  = '0;
                    r.finished   = 1'b1;
                end else begin
                    s            = take_step(s);
                    r.stepped    = 1'b1;
                    s.steps_left = cmd.step_count - 16'd1;
                    s.wait_left  = s.wait_reload;
                    s.moving     = 1'b1;
                end
            end
            stpseq_pkg::ACT_STOP: begin
                s.moving     = 1'b0;
                s.wait_left  = '0;
                s.steps_left = '0;
            end
            stpseq_pkg::ACT_TICK: begin
                if (s.moving) begin
                    if (s.wait_left != '0) s.wait_left = s.wait_left - 11'd1;
                    if (s.wait_left == '0) begin
                        if (s.steps_left != '0) begin
                            s            = take_step(s);
                            r.stepped    = 1'b1;
                            s.steps_left = s.steps_left - 16'd1;
                            s.wait_left  = s.wait_reload;
                        end else begin
                            s.moving   = 1'b0;
                            r.finished = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.coils    = s.coils;
        r.busy_res = s.moving;
        nxt        = s;
        return r;
    endfunction

    task automatic add_cmd(input logic [1:0] act, input logic dir,
                           input logic [stpseq_pkg::SPEED_W-1:0] spd,
                           input logic [15:0] cnt);
        stpseq_pkg::t_in_item  c;
        t_motor_state          n;
        stpseq_pkg::t_out_item r;
        c.action     = act;
        c.direction  = dir;
        c.speed      = spd;
        c.step_count = cnt;
        pending_commands.push_back(c);
        // ticks and stops while idle change nothing
        if (act == stpseq_pkg::ACT_START ||
            ((act == stpseq_pkg::ACT_TICK || act == stpseq_pkg::ACT_STOP) && plan_state.moving))
            planned_effective++;
        r = advance_motor(plan_state, c, n);
        plan_state = n;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_cmd(stpseq_pkg::ACT_TICK, 1'($urandom), 7'($urandom), 16'($urandom));
    endtask

    task automatic finish_move();
        while (plan_state.moving) add_ticks(1);
    endtask

    task automatic fill_commands();
        int                             roll;
        int                             pick;
        logic [stpseq_pkg::SPEED_W-1:0] spd;
        plan_state        = '0;
        planned_effective = 0;

        // idle commands, then reverse from reset with everything at its top value
        add_cmd(stpseq_pkg::ACT_TICK, 1'b1, 7'd127, 16'hFFFF);
        add_cmd(stpseq_pkg::ACT_STOP, 1'b0, 7'd0, 16'h0000);
        add_cmd(stpseq_pkg::ACT_NONE, 1'b1, 7'd127, 16'hFFFF);
        add_cmd(stpseq_pkg::ACT_START, 1'b1, 7'd127, 16'hFFFF);
        add_ticks(2);
        add_cmd(stpseq_pkg::ACT_START, 1'b0, 7'd0, 16'd2);
        add_ticks(1);
        add_cmd(stpseq_pkg::ACT_NONE, 1'b0, 7'd0, 16'd0);
        add_cmd(stpseq_pkg::ACT_STOP, 1'b1, 7'd127, 16'hFFFF);
        add_cmd(stpseq_pkg::ACT_START, 1'b0, 7'd100, 16'd0);
        add_cmd(stpseq_pkg::ACT_START, 1'b1, 7'd101, 16'd1);
        add_cmd(stpseq_pkg::ACT_START, 1'b0, 7'd0, 16'd0);
        add_cmd(stpseq_pkg::ACT_START, 1'b0, 7'd1, 16'd3);
        add_cmd(stpseq_pkg::ACT_STOP, 1'b0, 7'd1, 16'd3);
        add_cmd(stpseq_pkg::ACT_START, 1'b1, 7'd100, 16'd3);
        finish_move();

        while (planned_effective < CMD_TARGET) begin
            roll = $urandom_range(99, 0);
            if (roll < 70) begin
                pick = $urandom_range(99, 0);
                if (pick < 60)      spd = 7'($urandom_range(127, 100));
                else if (pick < 90) spd = 7'($urandom_range(99, 90));
                else                spd = 7'($urandom_range(89, 0));
                add_cmd(stpseq_pkg::ACT_START, 1'($urandom), spd, 16'($urandom_range(4, 0)));
                // slow moves and some fast ones get cut short
                if (spd < 7'd90 || $urandom_range(4, 0) == 0) begin
                    add_ticks($urandom_range(30, 0));
                    if ($urandom_range(1, 0) == 1)
                        add_cmd(stpseq_pkg::ACT_STOP, 1'($urandom), 7'($urandom),
                                16'($urandom));
                end else begin
                    finish_move();
                end
            end else if (roll < 85) begin
                add_cmd(stpseq_pkg::ACT_START, 1'($urandom), 7'($urandom), 16'($urandom));
                add_ticks($urandom_range(8, 0));
                add_cmd(stpseq_pkg::ACT_STOP, 1'($urandom), 7'($urandom), 16'($urandom));
            end else begin
                repeat ($urandom_range(3, 1))
                    add_cmd(2'($urandom), 1'($urandom), 7'($urandom), 16'($urandom));
            end
        end

        // a move at the longest wait, cut short by a stop
        add_cmd(stpseq_pkg::ACT_START, 1'b0, 7'd0, 16'd1);
        add_ticks(20);
        add_cmd(stpseq_pkg::ACT_STOP, 1'b0, 7'd0, 16'd0);
    endtask

    // Driver: hold the item until taken, then load the next or idle.
    always @(negedge i_clk) begin
        int send_idle;
        int recv_idle;
        if (cmds_accepted * 3 < total_cmds) begin
            send_idle = 33;
            recv_idle = 52;
        end else if (cmds_accepted * 3 < total_cmds * 2) begin
            send_idle = 52;
            recv_idle = 33;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                if (pending_commands.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_commands.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99, 0) >= recv_idle);
        end
    end

    // Monitor: predict on every accepted command, check every accepted result.
    always @(posedge i_clk) begin
        stpseq_pkg::t_out_item want;
        t_motor_state          next_model;
        logic                  moved;
        moved = 1'b0;
        in_took <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want      = advance_motor(dut_model, i_in_item, next_model);
                dut_model = next_model;
                results_due.push_back(want);
                cmds_accepted++;
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result coils=%b stepped=%b finished=%b busy=%b",
                             $time, o_out_item.coils, o_out_item.stepped,
                             o_out_item.finished, o_out_item.busy_res);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_item !== want) begin
                        errors++;
                        $display("%0t: mismatch expected coils=%b stepped=%b finished=%b busy=%b",
                                 $time, want.coils, want.stepped, want.finished, want.busy_res);
                        $display("%0t:            actual coils=%b stepped=%b finished=%b busy=%b",
                                 $time, o_out_item.coils, o_out_item.stepped,
                                 o_out_item.finished, o_out_item.busy_res);
                    end
                    steps_seen     += want.stepped;
                    moves_finished += want.finished;
                end
            end
            if (moved || (pending_commands.size() == 0 && !i_in_valid && results_due.size() == 0))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_out_ready    = 1'b0;
        in_took        = 1'b0;
        dut_model      = '0;
        cmds_accepted  = 0;
        errors         = 0;
        steps_seen     = 0;
        moves_finished = 0;
        stall_cycles   = 0;
        fill_commands();
        total_cmds = pending_commands.size();

        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_commands.size() > 0 || i_in_valid || results_due.size() > 0)
            @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);

        $display("Ran %0d commands through the sequencer: %0d steps, %0d completed moves,",
                 cmds_accepted, steps_seen, moves_finished);
        $display("with starts, stops and restarts in both directions; %0d mismatches", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
